/* rtl/utt_pkg.sv */
// Package for the UTF-16/UTF-32 to UTF-8 transcoder.
// Holds the mode and status codes, the record kinds and the record type
// that travels from the front end through the queue to the back end.
package utt_pkg;

    // Byte order / mode codes, as written to the configuration register
    localparam logic [2:0] MODE_PLAIN = 3'd0;
    localparam logic [2:0] MODE_UTF8  = 3'd1;
    localparam logic [2:0] MODE_U16LE = 3'd2;
    localparam logic [2:0] MODE_U16BE = 3'd3;
    localparam logic [2:0] MODE_U32LE = 3'd4;
    localparam logic [2:0] MODE_U32BE = 3'd5;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;

    // Queue depth (power of two)
    localparam int QueueDepth = 4;
    localparam int QueuePtrW  = $clog2(QueueDepth);

    // What one queued record expands into
    typedef enum logic [2:0] {
        REC_PASS,   // one byte passed through, with its own end mark
        REC_BAD,    // invalid UTF-8 lead byte
        REC_BIG,    // code unit of 0x10000 or more
        REC_U1,     // code unit giving one UTF-8 byte
        REC_U2,     // code unit giving two UTF-8 bytes
        REC_U3      // code unit giving three UTF-8 bytes
    } rec_kind_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic [15:0] data;      // passed byte in the low bits, or the code unit
        logic        last;      // end mark for a passed byte
    } rec_t;

endpackage

/* rtl/utt_front.sv */
// Front end of the transcoder: accepts raw bytes, gathers code units and
// classifies each character into a queue record. Holds the mode register.
// Depends on utt_pkg.
module utt_front
    import utt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [2:0] cfg_mode,
    output logic [2:0] mode,
    input  logic       in_valid,
    input  logic [7:0] in_byte,
    input  logic       queue_full,
    output logic       in_ready,
    output logic       push,
    output rec_t       push_rec
);

    logic [2:0]  mode_reg,  mode_next;
    logic [31:0] unit_reg,  unit_next;
    logic [2:0]  count_reg, count_next;
    logic [2:0]  left_reg,  left_next;

    logic        accept;
    logic        little;
    logic        wide;
    logic [31:0] unit_new;
    logic [2:0]  count_new;
    logic [2:0]  lead_len;

    // Character length from the top bits of a UTF-8 lead byte; zero if invalid
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        if ((b & 8'h80) == 8'h00)
            len = 3'd1;
        else if ((b & 8'he0) == 8'hc0)
            len = 3'd2;
        else if ((b & 8'hf0) == 8'he0)
            len = 3'd3;
        else if ((b & 8'hf8) == 8'hf0)
            len = 3'd4;
        else if ((b & 8'hfc) == 8'hf8)
            len = 3'd5;
        else if ((b & 8'hfe) == 8'hfc)
            len = 3'd6;
        else
            len = 3'd0;
        return len;
    endfunction

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign mode     = mode_reg;

    // Gathering of the next code unit in the configured byte order
    assign little    = (mode_reg == MODE_U16LE) || (mode_reg == MODE_U32LE);
    assign wide      = (mode_reg == MODE_U32LE) || (mode_reg == MODE_U32BE);
    assign unit_new  = little ? (unit_reg | ({24'd0, in_byte} << {count_reg[1:0], 3'b000}))
                              : {unit_reg[23:0], in_byte};
    assign count_new = count_reg + 3'd1;
    assign lead_len  = lead_length(in_byte);

    // Next state and the record pushed for each accepted byte
    always_comb
    begin
        mode_next     = mode_reg;
        unit_next     = unit_reg;
        count_next    = count_reg;
        left_next     = left_reg;
        push          = 1'b0;
        push_rec.kind = REC_PASS;
        push_rec.data = {8'd0, in_byte};
        push_rec.last = 1'b1;

        if (cfg_we)
        begin
            mode_next  = cfg_mode;
            unit_next  = '0;
            count_next = '0;
            left_next  = '0;
        end
        else if (accept)
        begin
            case (mode_reg)
                MODE_UTF8:
                begin
                    push = 1'b1;
                    if (left_reg != 3'd0)
                    begin
                        left_next     = left_reg - 3'd1;
                        push_rec.last = (left_reg == 3'd1);
                    end
                    else if (lead_len == 3'd0)
                    begin
                        push_rec.kind = REC_BAD;
                    end
                    else
                    begin
                        left_next     = lead_len - 3'd1;
                        push_rec.last = (lead_len == 3'd1);
                    end
                end
                MODE_U16LE, MODE_U16BE, MODE_U32LE, MODE_U32BE:
                begin
                    if (count_new == (wide ? 3'd4 : 3'd2))
                    begin
                        push          = 1'b1;
                        unit_next     = '0;
                        count_next    = '0;
                        push_rec.data = unit_new[15:0];
                        if (unit_new[31:16] != 16'd0)
                            push_rec.kind = REC_BIG;
                        else if (unit_new[15:7] == 9'd0)
                            push_rec.kind = REC_U1;
                        else if (unit_new[15:11] == 5'd0)
                            push_rec.kind = REC_U2;
                        else
                            push_rec.kind = REC_U3;
                    end
                    else
                    begin
                        unit_next  = unit_new;
                        count_next = count_new;
                    end
                end
                default:
                begin
                    push = 1'b1;
                end
            endcase
        end
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_PLAIN;
            unit_reg  <= '0;
            count_reg <= '0;
            left_reg  <= '0;
        end
        else
        begin
            mode_reg  <= mode_next;
            unit_reg  <= unit_next;
            count_reg <= count_next;
            left_reg  <= left_next;
        end
    end

endmodule

/* rtl/utt_queue.sv */
// Short record queue between the front end and the back end of the
// transcoder, so that each side stalls on its own. Depends on utt_pkg.
module utt_queue
    import utt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  rec_t push_rec,
    input  logic pop,
    output rec_t head_rec,
    output logic empty,
    output logic full
);

    rec_t                 entry_reg [QueueDepth];
    logic [QueuePtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QueuePtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QueuePtrW:0]   fill_reg,   fill_next;
    logic                 do_push;
    logic                 do_pop;

    assign empty    = (fill_reg == '0);
    assign full     = (fill_reg == QueueDepth[QueuePtrW:0]);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign head_rec = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + 1'b1;
        else if (do_pop && !do_push)
            fill_next = fill_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_rec;
    end

endmodule

/* rtl/utt_back.sv */
// Back end of the transcoder: expands each queued record into one to three
// UTF-8 bytes and holds them in an output register. Depends on utt_pkg.
module utt_back
    import utt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  rec_t       head_rec,
    input  logic       queue_empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic       out_last,
    output logic [1:0] out_status
);

    logic       valid_reg,  valid_next;
    logic [7:0] byte_reg,   byte_next;
    logic       last_reg,   last_next;
    logic [1:0] status_reg, status_next;
    logic [1:0] idx_reg,    idx_next;

    logic       load;
    logic [7:0] gen_byte;
    logic       gen_last;
    logic       gen_done;
    logic [1:0] gen_status;
    logic [15:0] v;

    assign v    = head_rec.data;
    assign load = !queue_empty && (!valid_reg || out_ready);

    // Byte number idx_reg of the head record; gen_done marks its final byte
    always_comb
    begin
        gen_byte   = 8'd0;
        gen_last   = 1'b1;
        gen_done   = 1'b1;
        gen_status = ST_OK;
        unique case (head_rec.kind)
            REC_PASS:
            begin
                gen_byte = v[7:0];
                gen_last = head_rec.last;
            end
            REC_BAD:
            begin
                gen_status = ST_BAD_LEAD;
            end
            REC_BIG:
            begin
                gen_status = ST_TOO_BIG;
            end
            REC_U1:
            begin
                gen_byte = {1'b0, v[6:0]};
            end
            REC_U2:
            begin
                if (idx_reg == 2'd0)
                begin
                    gen_byte = {3'b110, v[10:6]};
                    gen_last = 1'b0;
                    gen_done = 1'b0;
                end
                else
                    gen_byte = {2'b10, v[5:0]};
            end
            REC_U3:
            begin
                if (idx_reg == 2'd0)
                begin
                    gen_byte = {4'b1110, v[15:12]};
                    gen_last = 1'b0;
                    gen_done = 1'b0;
                end
                else if (idx_reg == 2'd1)
                begin
                    gen_byte = {2'b10, v[11:6]};
                    gen_last = 1'b0;
                    gen_done = 1'b0;
                end
                else
                    gen_byte = {2'b10, v[5:0]};
            end
            default:
            begin
                gen_byte = 8'd0;
            end
        endcase
    end

    // Output register load and record stepping; the final byte pops the record
    always_comb
    begin
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        status_next = status_reg;
        idx_next    = idx_reg;
        pop         = 1'b0;
        if (valid_reg && out_ready)
            valid_next = 1'b0;
        if (load)
        begin
            valid_next  = 1'b1;
            byte_next   = gen_byte;
            last_next   = gen_last;
            status_next = gen_status;
            if (gen_done)
            begin
                pop      = 1'b1;
                idx_next = 2'd0;
            end
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg   <= byte_next;
        last_reg   <= last_next;
        status_reg <= status_next;
    end

    assign out_valid  = valid_reg;
    assign out_byte   = byte_reg;
    assign out_last   = last_reg;
    assign out_status = status_reg;

endmodule

/* rtl/utf16_utf32_to_utf8_transcoder_unit.sv */
// Top level of the UTF-16/UTF-32 to UTF-8 transcoder.
// Instantiates utt_front, utt_queue and utt_back; depends on utt_pkg.
//
// Usage:
//   Raw text bytes enter on the s_axis channel, one byte per word. UTF-8
//   bytes leave on the m_axis channel: tdata is the byte, tlast marks the
//   last byte of a character, tuser is the status (0 ok, 1 invalid UTF-8
//   lead byte, 2 code unit of 0x10000 or more; tdata is zero on an error).
//   The byte order register at address 0 of the APB port selects plain,
//   UTF-8, UTF-16 LE/BE or UTF-32 LE/BE; writing it drops any partly
//   gathered character. Write it only while the block is idle.
//   A byte that completes a character is written into the record queue,
//   and its first output word is then loaded from the queue head into the
//   output register. The front end takes one input word per cycle while
//   the queue is not full; the output port gives one word per cycle while
//   the receiver is ready, so a unit that expands to three bytes gives three words.
//   The four-entry record queue between the two ends absorbs short bursts.
//   Reset clears the queue, the output register and all gathering state and
//   selects plain mode. When the receiver stalls, the output word holds,
//   the queue fills and s_axis_tready drops once it is full.
module utf16_utf32_to_utf8_transcoder_unit
    import utt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
    output logic        m_axis_tlast,
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    logic       cfg_we;
    logic [2:0] mode;
    logic       push;
    rec_t       push_rec;
    logic       pop;
    rec_t       head_rec;
    logic       queue_empty;
    logic       queue_full;

    // Register decode: only the byte order register, at any address with paddr[2] low
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {29'd0, mode} : 32'd0;

    utt_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_mode   (pwdata[2:0]),
        .mode       (mode),
        .in_valid   (s_axis_tvalid),
        .in_byte    (s_axis_tdata),
        .queue_full (queue_full),
        .in_ready   (s_axis_tready),
        .push       (push),
        .push_rec   (push_rec)
    );

    utt_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_rec (push_rec),
        .pop      (pop),
        .head_rec (head_rec),
        .empty    (queue_empty),
        .full     (queue_full)
    );

    utt_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_rec    (head_rec),
        .queue_empty (queue_empty),
        .pop         (pop),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_byte    (m_axis_tdata),
        .out_last    (m_axis_tlast),
        .out_status  (m_axis_tuser)
    );

endmodule

/* rtl/utt_checker.sv */
// Port-level checker for the transcoder top level, attached by bind.
// Depends on utt_pkg for the status codes.
module utt_checker
    import utt_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // Status is never the unused code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == ST_OK || m_axis_tuser == ST_BAD_LEAD
                           || m_axis_tuser == ST_TOO_BIG))
        else $error("unused status code on output");

    // An error word carries a zero byte and ends its character
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 8'd0 && m_axis_tlast))
        else $error("error word with data or without end mark");

    // A stalled output word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    // A written mode reads back in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (psel && penable && pwrite && paddr == 3'd0) ##1 (paddr == 3'd0) |->
            (prdata[2:0] == $past(pwdata[2:0]) && prdata[31:3] == 29'd0))
        else $error("mode register read back differs from last write");

endmodule

bind utf16_utf32_to_utf8_transcoder_unit utt_checker u_utt_checker (.*);
